@@ rtl/core/tfvs_pkg.sv @@
package tfvs_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned TICK_W      = 32;

    localparam logic [TICK_W-1:0] IGNITION_TICKS_RST = 32'd5000;
    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST   = 32'd3600000;

    localparam logic [CFG_INDEX_W-1:0] REG_IGNITION_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT   = 1'd1;

    localparam logic [5:0] CMD_START_FILL = 6'd0;
    localparam logic [5:0] CMD_STOP_FILL  = 6'd1;
    localparam logic [5:0] CMD_IGNITION   = 6'd2;
    localparam logic [5:0] CMD_FINAL_VENT = 6'd3;
    localparam logic [5:0] CMD_DONE       = 6'd4;
    localparam logic [5:0] CMD_ABORT      = 6'd5;
    localparam logic [5:0] CMD_SERVO      = 6'd6;
    localparam logic [5:0] CMD_READY      = 6'd7;
    localparam logic [5:0] CMD_HEAT_ON    = 6'd8;
    localparam logic [5:0] CMD_HEAT_OFF   = 6'd9;

    localparam logic [1:0] MAIN_CLOSED  = 2'd0;
    localparam logic [1:0] MAIN_IGN_SET = 2'd1;
    localparam logic [1:0] MAIN_FULL    = 2'd2;

    localparam logic [4:0] NUM_STATES = 5'd13;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_WAIT_INIT,
        ST_WAIT_READY,
        ST_WAIT_FILL,
        ST_FILL_RUN,
        ST_WAIT_IGNITION,
        ST_IGNITE,
        ST_BURN,
        ST_VENT_OUT,
        ST_DONE,
        ST_ABORT_FILL,
        ST_BURN_ABORT,
        ST_SERVO
    } phase_t;

    typedef struct packed {
        logic signed [6:0] event_code;
        logic              interface_ready;
        logic              client_active;
    } in_item_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       vent_open;
        logic [1:0] main_position;
        logic       pinhole_valve;
        logic       fill_valve;
        logic       heater_out;
        logic       failsafe_fired;
    } out_item_t;

    typedef struct packed {
        logic       vent;
        logic [1:0] main;
        logic       pinhole;
        logic       fill;
    } valves_t;

    // fixed valve settings per state; servo control is handled separately
    function automatic valves_t state_valves(phase_t st);
        valves_t v;
        v = '{vent: 1'b0, main: MAIN_CLOSED, pinhole: 1'b0, fill: 1'b0};
        case (st)
            ST_FILL_RUN:
            begin
                v.pinhole = 1'b1;
                v.fill    = 1'b1;
            end
            ST_IGNITE:        v.main = MAIN_IGN_SET;
            ST_BURN:          v.main = MAIN_FULL;
            ST_VENT_OUT:
            begin
                v.vent    = 1'b1;
                v.pinhole = 1'b1;
            end
            ST_DONE:
            begin
                v.main    = MAIN_FULL;
                v.pinhole = 1'b1;
            end
            default:          v = v;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/test_fire_valve_sequencer.sv @@
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while in_stall is low; the next-state logic completes in one pass.
// in_stall is raised only while a held result is stalled downstream.
// Reset (rst_n low, asynchronous): init state, counters and flags cleared,
// heater off, servo valves closed, config registers at their defaults.
module test_fire_valve_sequencer
    import tfvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [TICK_W-1:0] ignition_ticks_reg;
    logic [TICK_W-1:0] idle_timeout_reg;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] phase_ticks_reg, phase_ticks_next;
    logic [TICK_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic              client_seen_reg, client_seen_next;
    logic              failsafe_done_reg, failsafe_done_next;
    logic              heater_flag_reg, heater_flag_next;
    logic [4:0]        servo_valves_reg, servo_valves_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              in_accept;
    phase_t            st;
    logic              has_code;
    logic [5:0]        code;
    logic [TICK_W-1:0] ticks_inc;
    logic              fire;
    logic              cmd_take;
    phase_t            cmd_tgt;
    valves_t           valves;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign has_code = !in_data.event_code[6];
    assign code     = in_data.event_code[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignition_ticks_reg <= IGNITION_TICKS_RST;
            idle_timeout_reg   <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IGNITION_TICKS)
                ignition_ticks_reg <= cfg_data;
            else if (cfg_index == REG_IDLE_TIMEOUT)
                idle_timeout_reg <= cfg_data;
        end
    end

    always_comb
    begin
        st = phase_reg;
        if (phase_reg > ST_SERVO)
            st = ST_INIT;

        ticks_inc = (phase_ticks_reg == '1) ? phase_ticks_reg : phase_ticks_reg + 32'd1;

        client_seen_next = client_seen_reg;
        idle_ticks_next  = idle_ticks_reg;
        if (in_data.client_active)
        begin
            client_seen_next = 1'b1;
            idle_ticks_next  = '0;
        end
        else if (client_seen_reg && idle_ticks_reg != '1)
        begin
            idle_ticks_next = idle_ticks_reg + 32'd1;
        end

        fire = (st >= ST_WAIT_READY) && client_seen_next && !failsafe_done_reg
            && (idle_ticks_next > idle_timeout_reg);

        cmd_take          = 1'b0;
        cmd_tgt           = st;
        heater_flag_next  = heater_flag_reg;
        servo_valves_next = servo_valves_reg;

        case (st)
            ST_INIT:
            begin
                cmd_take = 1'b1;
                cmd_tgt  = ST_WAIT_INIT;
            end
            ST_WAIT_INIT:
            begin
                if (in_data.interface_ready)
                begin
                    cmd_take = 1'b1;
                    cmd_tgt  = ST_WAIT_READY;
                end
            end
            ST_SERVO:
            begin
                if (has_code)
                begin
                    if (code[0])
                        servo_valves_next = code[5:1];
                    else if (code[5:1] < NUM_STATES)
                    begin
                        cmd_take = 1'b1;
                        cmd_tgt  = phase_t'(code[4:1]);
                    end
                end
            end
            default:
            begin
                if (has_code)
                begin
                    case (code)
                        CMD_HEAT_ON:  heater_flag_next = 1'b1;
                        CMD_HEAT_OFF: heater_flag_next = 1'b0;
                        CMD_START_FILL:
                        begin
                            cmd_take = st inside {ST_WAIT_FILL, ST_ABORT_FILL};
                            cmd_tgt  = ST_FILL_RUN;
                        end
                        CMD_STOP_FILL:
                        begin
                            cmd_take = (st == ST_FILL_RUN);
                            cmd_tgt  = ST_WAIT_IGNITION;
                        end
                        CMD_IGNITION:
                        begin
                            cmd_take = st inside {ST_WAIT_IGNITION, ST_ABORT_FILL};
                            cmd_tgt  = ST_IGNITE;
                        end
                        CMD_FINAL_VENT:
                        begin
                            cmd_take = st inside {ST_BURN, ST_ABORT_FILL, ST_BURN_ABORT};
                            cmd_tgt  = ST_VENT_OUT;
                        end
                        CMD_DONE:
                        begin
                            cmd_take = (st == ST_VENT_OUT);
                            cmd_tgt  = ST_DONE;
                        end
                        CMD_ABORT:
                        begin
                            if (st inside {[ST_WAIT_FILL:ST_WAIT_IGNITION]})
                            begin
                                cmd_take = 1'b1;
                                cmd_tgt  = ST_ABORT_FILL;
                            end
                            else if (st inside {ST_IGNITE, ST_BURN})
                            begin
                                cmd_take = 1'b1;
                                cmd_tgt  = ST_BURN_ABORT;
                            end
                        end
                        CMD_SERVO:
                        begin
                            cmd_take = 1'b1;
                            cmd_tgt  = ST_SERVO;
                        end
                        CMD_READY:
                        begin
                            cmd_take = (st == ST_WAIT_READY);
                            cmd_tgt  = ST_WAIT_FILL;
                        end
                        default:      cmd_take = 1'b0;
                    endcase
                end
                // ignition timer only when no command moved us
                if (st == ST_IGNITE && !cmd_take && ticks_inc >= ignition_ticks_reg)
                begin
                    cmd_take = 1'b1;
                    cmd_tgt  = ST_BURN;
                end
            end
        endcase

        // failsafe overrides any command or timer transition
        failsafe_done_next = failsafe_done_reg || fire;
        if (fire)
        begin
            phase_next       = ST_VENT_OUT;
            phase_ticks_next = '0;
        end
        else if (cmd_take)
        begin
            phase_next       = cmd_tgt;
            phase_ticks_next = '0;
        end
        else
        begin
            phase_next       = st;
            phase_ticks_next = ticks_inc;
        end

        if (st == ST_SERVO)
        begin
            valves.vent    = servo_valves_next[0];
            valves.main    = servo_valves_next[2] ? MAIN_FULL : MAIN_CLOSED;
            valves.pinhole = servo_valves_next[3];
            valves.fill    = servo_valves_next[4];
        end
        else
        begin
            valves = state_valves(st);
        end

        out_data_next.phase          = st;
        out_data_next.vent_open      = valves.vent;
        out_data_next.main_position  = valves.main;
        out_data_next.pinhole_valve  = valves.pinhole;
        out_data_next.fill_valve     = valves.fill;
        out_data_next.heater_out     = heater_flag_reg;
        out_data_next.failsafe_fired = fire;

        if (in_accept)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ST_INIT;
            phase_ticks_reg   <= '0;
            idle_ticks_reg    <= '0;
            client_seen_reg   <= 1'b0;
            failsafe_done_reg <= 1'b0;
            heater_flag_reg   <= 1'b0;
            servo_valves_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg         <= phase_next;
                phase_ticks_reg   <= phase_ticks_next;
                idle_ticks_reg    <= idle_ticks_next;
                client_seen_reg   <= client_seen_next;
                failsafe_done_reg <= failsafe_done_next;
                heater_flag_reg   <= heater_flag_next;
                servo_valves_reg  <= servo_valves_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_fire_to_venting: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && fire |=> phase_reg == ST_VENT_OUT)
        else $error("failsafe did not force final venting");

    a_fire_once: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && fire |-> !failsafe_done_reg)
        else $error("failsafe fired twice");

    a_servo_heater_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && st == ST_SERVO |=> heater_flag_reg == $past(heater_flag_reg))
        else $error("heater changed in servo control");
`endif

endmodule
